>>> hw/rtl/rese_pkg.sv
// ---------------------------------------------------------------------------
// rese_pkg: shared types and widths for the rectangle edge intersect unit
// Coordinate widths, derived internal widths and edge select codes.
// ---------------------------------------------------------------------------
`default_nettype none

package rese_pkg;

    // Coordinate width (Q12.4 at the default), half sizes are two bits narrower
    localparam int COORD_BITS = 16;
    localparam int HALF_BITS  = COORD_BITS - 2;

    // Internal widths: edge start, segment direction, start offset, edge length
    localparam int ES_W  = COORD_BITS + 1;
    localparam int TV_W  = COORD_BITS + 1;
    localparam int D_W   = COORD_BITS + 2;
    localparam int LEN_W = COORD_BITS;
    // Cross products and their differences, with room for a negation
    localparam int NW    = 2 * COORD_BITS + 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [HALF_BITS-1:0]  half_t;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_BOTTOM = 2'd1,
        EDGE_LEFT   = 2'd2,
        EDGE_RIGHT  = 2'd3
    } edge_sel_t;

endpackage

`default_nettype wire

>>> hw/rtl/rect_edge_segment_intersect_unit.sv
// ---------------------------------------------------------------------------
// rect_edge_segment_intersect_unit: segment versus rectangle edge test
// Exact fixed-point crossing test of one segment against one chosen edge of
// an axis-aligned rectangle, using cross products and no division.
// ---------------------------------------------------------------------------
// Usage:
//   Drive the rectangle, the edge select and both segment endpoints and
//   raise start. A transfer happens at each rising edge with start high and
//   busy low. busy is always low: the six-stage pipeline never stalls, so a
//   new item may be issued every cycle (one item per cycle sustained).
//   done rises when the item leaves the last stage, with the result on hit
//   and parallel, for one cycle; it is taken at the edge that ends that
//   cycle. Results leave in issue order.
//   Stages: edge start and segment direction, start offset, the four cross
//   products (one multiplier each), numerator difference, sign adjust and
//   zero test, final range compares.
//   The receiver cannot hold results off, so nothing waits inside the
//   block. Reset (rst_n low) clears all stage valid bits at once; items
//   in flight are dropped and done stays low until a new item arrives.
//   parallel flags a zero denominator (degenerate edge or segment, or a
//   segment parallel to the edge); hit is then 0.
// ---------------------------------------------------------------------------
`default_nettype none

module rect_edge_segment_intersect_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            edge_select,
    input  wire rese_pkg::coord_t      rect_center_x,
    input  wire rese_pkg::coord_t      rect_center_y,
    input  wire rese_pkg::half_t       rect_half_width,
    input  wire rese_pkg::half_t       rect_half_height,
    input  wire rese_pkg::coord_t      seg_first_x,
    input  wire rese_pkg::coord_t      seg_first_y,
    input  wire rese_pkg::coord_t      seg_second_x,
    input  wire rese_pkg::coord_t      seg_second_y,
    output logic                       done,
    output logic                       hit,
    output logic                       parallel
);

    import rese_pkg::*;

    // Valid bits, one per stage
    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    // Stage 1: edge start, edge length, segment direction
    logic                    s1_horiz_reg, s1_horiz_next;
    logic signed [ES_W-1:0]  s1_esx_reg, s1_esx_next;
    logic signed [ES_W-1:0]  s1_esy_reg, s1_esy_next;
    logic signed [LEN_W-1:0] s1_len_reg, s1_len_next;
    logic signed [TV_W-1:0]  s1_tvx_reg, s1_tvx_next;
    logic signed [TV_W-1:0]  s1_tvy_reg, s1_tvy_next;
    coord_t                  s1_p2x_reg, s1_p2x_next;
    coord_t                  s1_p2y_reg, s1_p2y_next;

    // Stage 2: offset of the segment start from the edge start
    logic                    s2_horiz_reg;
    logic signed [LEN_W-1:0] s2_len_reg;
    logic signed [TV_W-1:0]  s2_tvx_reg, s2_tvy_reg;
    logic signed [D_W-1:0]   s2_dx_reg, s2_dx_next;
    logic signed [D_W-1:0]   s2_dy_reg, s2_dy_next;

    // Stage 3: raw products
    logic                    s3_horiz_reg;
    logic signed [NW-1:0]    s3_pa_reg, s3_pa_next;
    logic signed [NW-1:0]    s3_pb_reg, s3_pb_next;
    logic signed [NW-1:0]    s3_pden_reg, s3_pden_next;
    logic signed [NW-1:0]    s3_pn2_reg, s3_pn2_next;

    // Stage 4: denominator and numerators
    logic signed [NW-1:0]    s4_den_reg, s4_den_next;
    logic signed [NW-1:0]    s4_n1_reg, s4_n1_next;
    logic signed [NW-1:0]    s4_n2_reg, s4_n2_next;

    // Stage 5: sign adjusted values and zero test
    logic                    s5_par_reg, s5_par_next;
    logic signed [NW-1:0]    s5_den_reg, s5_den_next;
    logic signed [NW-1:0]    s5_n1_reg, s5_n1_next;
    logic signed [NW-1:0]    s5_n2_reg, s5_n2_next;

    // Stage 6: result
    logic                    hit_reg, hit_next;
    logic                    par_reg, par_next;

    logic signed [ES_W-1:0]  cx_ext, cy_ext, w_ext, h_ext;
    logic                    den_neg;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Valid chain
    assign vld_next = {vld_reg[4:0], start};

    // Stage 1 logic
    always_comb
    begin
        cx_ext = ES_W'(rect_center_x);
        cy_ext = ES_W'(rect_center_y);
        w_ext  = signed'({{(ES_W-HALF_BITS){1'b0}}, rect_half_width});
        h_ext  = signed'({{(ES_W-HALF_BITS){1'b0}}, rect_half_height});
        s1_horiz_next = (edge_select == EDGE_TOP) || (edge_select == EDGE_BOTTOM);
        s1_esx_next = (edge_select == EDGE_RIGHT) ? (cx_ext + w_ext) : (cx_ext - w_ext);
        s1_esy_next = (edge_select == EDGE_BOTTOM) ? (cy_ext + h_ext) : (cy_ext - h_ext);
        // edge length is twice the chosen half size
        s1_len_next = s1_horiz_next ? signed'({1'b0, rect_half_width, 1'b0})
                                    : signed'({1'b0, rect_half_height, 1'b0});
        s1_tvx_next = TV_W'(seg_first_x) - TV_W'(seg_second_x);
        s1_tvy_next = TV_W'(seg_first_y) - TV_W'(seg_second_y);
        s1_p2x_next = seg_second_x;
        s1_p2y_next = seg_second_y;
    end

    // Stage 2 logic
    always_comb
    begin
        s2_dx_next = D_W'(s1_p2x_reg) - D_W'(s1_esx_reg);
        s2_dy_next = D_W'(s1_p2y_reg) - D_W'(s1_esy_reg);
    end

    // Stage 3 logic: one edge component is always zero
    always_comb
    begin
        s3_pa_next   = NW'(s2_dx_reg) * NW'(s2_tvy_reg);
        s3_pb_next   = NW'(s2_dy_reg) * NW'(s2_tvx_reg);
        s3_pden_next = NW'(s2_len_reg) * (s2_horiz_reg ? NW'(s2_tvy_reg) : NW'(s2_tvx_reg));
        s3_pn2_next  = NW'(s2_len_reg) * (s2_horiz_reg ? NW'(s2_dy_reg) : NW'(s2_dx_reg));
    end

    // Stage 4 logic: den = ev x tv, n1 = d x tv, n2 = d x ev
    always_comb
    begin
        s4_n1_next  = s3_pa_reg - s3_pb_reg;
        s4_den_next = s3_horiz_reg ? s3_pden_reg : -s3_pden_reg;
        s4_n2_next  = s3_horiz_reg ? -s3_pn2_reg : s3_pn2_reg;
    end

    // Stage 5 logic: make the denominator non-negative and flag zero
    always_comb
    begin
        den_neg     = s4_den_reg[NW-1];
        s5_par_next = (s4_den_reg == '0);
        s5_den_next = den_neg ? -s4_den_reg : s4_den_reg;
        s5_n1_next  = den_neg ? -s4_n1_reg  : s4_n1_reg;
        s5_n2_next  = den_neg ? -s4_n2_reg  : s4_n2_reg;
    end

    // Stage 6 logic: 0 <= n <= den for both numerators
    always_comb
    begin
        par_next = s5_par_reg;
        hit_next = !s5_par_reg
                   && !s5_n1_reg[NW-1] && (s5_n1_reg <= s5_den_reg)
                   && !s5_n2_reg[NW-1] && (s5_n2_reg <= s5_den_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_horiz_reg <= s1_horiz_next;
        s1_esx_reg   <= s1_esx_next;
        s1_esy_reg   <= s1_esy_next;
        s1_len_reg   <= s1_len_next;
        s1_tvx_reg   <= s1_tvx_next;
        s1_tvy_reg   <= s1_tvy_next;
        s1_p2x_reg   <= s1_p2x_next;
        s1_p2y_reg   <= s1_p2y_next;

        s2_horiz_reg <= s1_horiz_reg;
        s2_len_reg   <= s1_len_reg;
        s2_tvx_reg   <= s1_tvx_reg;
        s2_tvy_reg   <= s1_tvy_reg;
        s2_dx_reg    <= s2_dx_next;
        s2_dy_reg    <= s2_dy_next;

        s3_horiz_reg <= s2_horiz_reg;
        s3_pa_reg    <= s3_pa_next;
        s3_pb_reg    <= s3_pb_next;
        s3_pden_reg  <= s3_pden_next;
        s3_pn2_reg   <= s3_pn2_next;

        s4_den_reg   <= s4_den_next;
        s4_n1_reg    <= s4_n1_next;
        s4_n2_reg    <= s4_n2_next;

        s5_par_reg   <= s5_par_next;
        s5_den_reg   <= s5_den_next;
        s5_n1_reg    <= s5_n1_next;
        s5_n2_reg    <= s5_n2_next;

        hit_reg      <= hit_next;
        par_reg      <= par_next;
    end

    // Result ports
    assign done     = vld_reg[5];
    assign hit      = hit_reg;
    assign parallel = par_reg;

endmodule

`default_nettype wire
